// ===== hdl/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and codes for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_MAX_BODY        = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FRAMES_PER_POLL = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_QUEUE_SLOTS     = 2'd2;

   localparam logic [31:0] MAX_BODY_RESET        = 32'd65536;
   localparam logic [15:0] FRAMES_PER_POLL_RESET = 16'd16;
   localparam logic [15:0] QUEUE_SLOTS_RESET     = 16'd64;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_POLL   = 2'd1;
   localparam logic [1:0] KIND_FREED  = 2'd2;
   localparam logic [1:0] KIND_CLOSED = 2'd3;

   localparam logic [2:0] ST_ACK        = 3'd0;
   localparam logic [2:0] ST_LENGTH     = 3'd1;
   localparam logic [2:0] ST_BODY       = 3'd2;
   localparam logic [2:0] ST_FRAME_DONE = 3'd3;
   localparam logic [2:0] ST_REFUSED    = 3'd4;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
   localparam logic [2:0] ST_CLOSED     = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  body_byte;
      logic [31:0] frame_length;
      logic        last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic                     wr_en;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  wr_data;
   } csr_wr_type;

endpackage

// ===== hdl/lpfr_core.sv =====
// ----------------------------------------------------------------------------
// lpfr_core
// Deframing state, budget and occupancy tracking, and configuration registers.
// Computes the response word for the current request word.
// ----------------------------------------------------------------------------
module lpfr_core import lpfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr,
   input  logic       accept,
   input  req_type    req,
   output rsp_type    rsp
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEN,
      PH_BODY,
      PH_CLOSED
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] bytes_used_ff, bytes_used_in;
   logic [31:0] length_shift_ff, length_shift_in;
   logic [31:0] body_length_ff, body_length_in;
   logic [15:0] frame_budget_ff, frame_budget_in;
   logic [15:0] queued_frames_ff, queued_frames_in;

   logic [31:0] max_body_ff;
   logic [15:0] frames_per_poll_ff;
   logic [15:0] queue_slots_ff;

   logic [15:0] free_slots;
   logic [31:0] shifted;
   logic [31:0] used_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff        <= MAX_BODY_RESET;
         frames_per_poll_ff <= FRAMES_PER_POLL_RESET;
         queue_slots_ff     <= QUEUE_SLOTS_RESET;
      end else if (csr.wr_en) begin
         unique case (csr.index)
            CSR_MAX_BODY:        max_body_ff        <= csr.wr_data;
            CSR_FRAMES_PER_POLL: frames_per_poll_ff <= csr.wr_data[15:0];
            CSR_QUEUE_SLOTS:     queue_slots_ff     <= csr.wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      free_slots = (queue_slots_ff > queued_frames_ff) ?
                   (queue_slots_ff - queued_frames_ff) : 16'd0;
      shifted    = (phase_ff == PH_IDLE) ? {24'd0, req.data_byte}
                                         : {length_shift_ff[23:0], req.data_byte};
      used_next  = (phase_ff == PH_IDLE) ? 32'd1 : (bytes_used_ff + 32'd1);

      phase_in         = phase_ff;
      bytes_used_in    = bytes_used_ff;
      length_shift_in  = length_shift_ff;
      body_length_in   = body_length_ff;
      frame_budget_in  = frame_budget_ff;
      queued_frames_in = queued_frames_ff;

      rsp.status        = ST_ACK;
      rsp.body_byte     = 8'd0;
      rsp.frame_length  = 32'd0;
      rsp.last_of_frame = 1'b0;

      if (phase_ff == PH_CLOSED) begin
         rsp.status = ST_CLOSED;
      end else begin
         case (req.kind)
            KIND_CLOSED: begin
               phase_in   = PH_CLOSED;
               rsp.status = ST_CLOSED;
            end
            KIND_POLL: begin
               if (phase_ff == PH_IDLE) begin
                  frame_budget_in = (frames_per_poll_ff < free_slots) ?
                                    frames_per_poll_ff : free_slots;
               end
            end
            KIND_FREED: begin
               if (queued_frames_ff != 16'd0) begin
                  queued_frames_in = queued_frames_ff - 16'd1;
               end
            end
            default: begin
               if (phase_ff == PH_IDLE && frame_budget_ff == 16'd0) begin
                  rsp.status = ST_REFUSED;
               end else if (phase_ff == PH_IDLE || phase_ff == PH_LEN) begin
                  if (phase_ff == PH_IDLE) begin
                     frame_budget_in = frame_budget_ff - 16'd1;
                  end
                  length_shift_in = shifted;
                  bytes_used_in   = used_next;
                  phase_in        = PH_LEN;
                  rsp.status       = ST_LENGTH;
                  rsp.frame_length = shifted;
                  if (used_next >= 32'd4) begin
                     body_length_in = shifted;
                     bytes_used_in  = 32'd0;
                     if (shifted == 32'd0 || shifted > max_body_ff) begin
                        phase_in   = PH_CLOSED;
                        rsp.status = ST_BAD_LENGTH;
                     end else begin
                        phase_in = PH_BODY;
                     end
                  end
               end else begin
                  rsp.body_byte    = req.data_byte;
                  rsp.frame_length = body_length_ff;
                  bytes_used_in    = used_next;
                  if (used_next >= body_length_ff) begin
                     phase_in          = PH_IDLE;
                     bytes_used_in     = 32'd0;
                     rsp.status        = ST_FRAME_DONE;
                     rsp.last_of_frame = 1'b1;
                     if (queued_frames_ff != 16'hFFFF) begin
                        queued_frames_in = queued_frames_ff + 16'd1;
                     end
                  end else begin
                     rsp.status = ST_BODY;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bytes_used_ff    <= 32'd0;
         length_shift_ff  <= 32'd0;
         body_length_ff   <= 32'd0;
         frame_budget_ff  <= 16'd0;
         queued_frames_ff <= 16'd0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         bytes_used_ff    <= bytes_used_in;
         length_shift_ff  <= length_shift_in;
         body_length_ff   <= body_length_in;
         frame_budget_ff  <= frame_budget_in;
         queued_frames_ff <= queued_frames_in;
      end
   end

endmodule

// ===== hdl/length_prefixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Deframes a byte stream of 4-byte big-endian length-prefixed frames.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while req_stall is low (data byte, poll,
// slot freed or peer closed) and returns exactly one registered response word
// for each. All per-word work is a single pass through the deframing
// logic into the response or skid register; a two-entry output stage (response
// register plus skid register) keeps req_stall registered, so input flows at
// one word per cycle as long as rsp_stall stays low, and req_stall rises only
// once both entries hold words the consumer has not taken. A bad length or
// peer close leaves the receiver closed until reset.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver import lpfr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data
);

   csr_wr_type csr;
   rsp_type    result;
   logic       accept;
   logic       take;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   assign csr.wr_en   = csr_wr_en;
   assign csr.index   = csr_index;
   assign csr.wr_data = csr_wr_data;

   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   lpfr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .accept (accept),
      .req    (req_data),
      .rsp    (result)
   );

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= accept;
         if (accept) begin
            out_data_ff <= result;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= result;
      end
   end

endmodule

// ===== tb/sv/lpfr_frame_check.sv =====
// ----------------------------------------------------------------------------
// lpfr_frame_check
// Watches the request, response and register ports of the frame receiver,
// keeps its own model of the deframing state and compares every response
// word, field by field, with the oldest predicted word.
// ----------------------------------------------------------------------------
module lpfr_frame_check import lpfr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   output int                       fail_count,
   output int                       pending
);

   typedef enum logic [1:0] {RX_IDLE, RX_LENGTH, RX_BODY, RX_CLOSED} rx_phase_type;

   logic [31:0] max_body;
   logic [15:0] frames_per_poll;
   logic [15:0] queue_slots;

   rx_phase_type rx_phase;
   logic [2:0]  length_count;
   logic [31:0] length_acc;
   logic [31:0] body_length;
   logic [31:0] body_count;
   logic [15:0] frame_budget;
   logic [15:0] queued_frames;

   rsp_type     expected_rsp[$];
   int          rsp_count;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on response word %0d: %s is %0h, expected %0h",
               rsp_count, field, got, want);
      fail_count++;
   endtask

   function automatic rsp_type predict_word(input req_type word);
      rsp_type     r;
      logic [15:0] free_slots;
      r = '0;
      if (rx_phase == RX_CLOSED) begin
         r.status = ST_CLOSED;
         return r;
      end
      case (word.kind)
         KIND_CLOSED: begin
            rx_phase = RX_CLOSED;
            r.status = ST_CLOSED;
         end
         KIND_POLL: begin
            if (rx_phase == RX_IDLE) begin
               free_slots   = (queue_slots > queued_frames) ? queue_slots - queued_frames : '0;
               frame_budget = (frames_per_poll < free_slots) ? frames_per_poll : free_slots;
            end
            r.status = ST_ACK;
         end
         KIND_FREED: begin
            if (queued_frames != '0)
               queued_frames--;
            r.status = ST_ACK;
         end
         default: begin
            if (rx_phase == RX_IDLE) begin
               if (frame_budget == '0) begin
                  r.status = ST_REFUSED;
                  return r;
               end
               frame_budget--;
               rx_phase     = RX_LENGTH;
               length_count = '0;
               length_acc   = '0;
            end
            if (rx_phase == RX_LENGTH) begin
               length_acc = {length_acc[23:0], word.data_byte};
               length_count++;
               r.status       = ST_LENGTH;
               r.frame_length = length_acc;
               if (length_count == 3'd4) begin
                  body_length = length_acc;
                  body_count  = '0;
                  if (body_length == '0 || body_length > max_body) begin
                     rx_phase = RX_CLOSED;
                     r.status = ST_BAD_LENGTH;
                  end else begin
                     rx_phase = RX_BODY;
                  end
               end
            end else begin
               body_count++;
               r.body_byte    = word.data_byte;
               r.frame_length = body_length;
               if (body_count >= body_length) begin
                  rx_phase = RX_IDLE;
                  if (queued_frames != 16'hFFFF)
                     queued_frames++;
                  r.status        = ST_FRAME_DONE;
                  r.last_of_frame = 1'b1;
               end else begin
                  r.status = ST_BODY;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         max_body        = MAX_BODY_RESET;
         frames_per_poll = FRAMES_PER_POLL_RESET;
         queue_slots     = QUEUE_SLOTS_RESET;
         rx_phase        = RX_IDLE;
         length_count    = '0;
         length_acc      = '0;
         body_length     = '0;
         body_count      = '0;
         frame_budget    = '0;
         queued_frames   = '0;
         rsp_count       = 0;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_BODY:        max_body = csr_wr_data;
               CSR_FRAMES_PER_POLL: frames_per_poll = csr_wr_data[15:0];
               CSR_QUEUE_SLOTS:     queue_slots = csr_wr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected word, status", rsp_data.status, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.body_byte !== want.body_byte)
                  report_mismatch("body_byte", rsp_data.body_byte, want.body_byte);
               if (rsp_data.frame_length !== want.frame_length)
                  report_mismatch("frame_length", rsp_data.frame_length, want.frame_length);
               if (rsp_data.last_of_frame !== want.last_of_frame)
                  report_mismatch("last_of_frame", rsp_data.last_of_frame, want.last_of_frame);
            end
            rsp_count++;
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(predict_word(req_data));
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the frame receiver testbench. Drives directed and random request
// words with random pacing on both channels, rewrites the registers between
// phases, ends with a close of the receiver, and gives the verdict from the
// failure count of the response checker or an idle watchdog.
// ----------------------------------------------------------------------------
module tb;
   import lpfr_pkg::*;

   localparam int IdleLimit     = 4000;
   localparam int HoldOffCycles = 300;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wr_data;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   rsp_type                  rsp_data;
   int                       fail_count;
   int                       pending;

   // stimulus-side bookkeeping, keeps the random stream inside legal frames
   logic [31:0] cfg_max_body        = MAX_BODY_RESET;
   int          cfg_frames_per_poll = FRAMES_PER_POLL_RESET;
   int          cfg_queue_slots     = QUEUE_SLOTS_RESET;
   int          frames_owed         = 0;
   int          budget_left         = 0;
   int          words_sent          = 0;
   int          calm_req            = 0;
   int          calm_rsp            = 0;
   int          idle_cycles         = 0;
   bit          hold_off_armed      = 1'b0;

   always #5 clock = ~clock;

   length_prefixed_frame_receiver i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   lpfr_frame_check i_frame_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(30, 120);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_len();
      int cap;
      cap = (cfg_max_body < 40) ? cfg_max_body : 40;
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, (cap < 6) ? cap : 6);
      return $urandom_range(1, cap);
   endfunction

   task automatic send_word(input logic [1:0] word_kind, input logic [7:0] value);
      int gap;
      gap = pick_gap(calm_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: word_kind, data_byte: value};
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_poll();
      int free_slots;
      send_word(KIND_POLL, $urandom);
      free_slots  = (cfg_queue_slots > frames_owed) ? cfg_queue_slots - frames_owed : 0;
      budget_left = (cfg_frames_per_poll < free_slots) ? cfg_frames_per_poll : free_slots;
   endtask

   task automatic send_freed();
      send_word(KIND_FREED, $urandom);
      if (frames_owed > 0)
         frames_owed--;
   endtask

   task automatic mid_frame_noise();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         send_word(KIND_POLL, $urandom);
      else if (r < 7)
         send_freed();
   endtask

   task automatic send_frame(input logic [31:0] len);
      for (int i = 3; i >= 0; i--) begin
         if (i < 3)
            mid_frame_noise();
         send_word(KIND_DATA, len[8*i +: 8]);
      end
      budget_left--;
      for (int unsigned n = 0; n < len; n++) begin
         mid_frame_noise();
         send_word(KIND_DATA, $urandom);
      end
      frames_owed++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] fm, input logic [15:0] fpp,
                            input logic [15:0] slots);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MAX_BODY;
      csr_wr_data <= fm;
      @(posedge clock);
      csr_index   <= CSR_FRAMES_PER_POLL;
      csr_wr_data <= {16'h0, fpp};
      @(posedge clock);
      csr_index   <= CSR_QUEUE_SLOTS;
      csr_wr_data <= {16'h0, slots};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_max_body        = fm;
      cfg_frames_per_poll = fpp;
      cfg_queue_slots     = slots;
   endtask

   task automatic random_phase(input int words);
      int stop;
      int r;
      stop = words_sent + words;
      while (words_sent < stop) begin
         r = $urandom_range(0, 99);
         if (budget_left > 0) begin
            if (r < 5)
               send_freed();
            else if (r < 10)
               send_poll();
            else
               send_frame(pick_len());
         end else begin
            if (r < 35 || (frames_owed >= cfg_queue_slots && r < 75))
               send_freed();
            else if (r < 80)
               send_poll();
            else
               send_word(KIND_DATA, $urandom);
         end
      end
   endtask

   initial begin : rsp_pacing
      int run;
      int gap;
      forever begin
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         gap = pick_gap(calm_rsp);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] fm;
      logic [31:0] len;
      logic [15:0] fpp;
      logic [15:0] slots;
      int          close_mode;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      req_valid   <= 1'b0;
      req_data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no budget before the first poll, freed on an empty queue
      send_word(KIND_DATA, 8'hFF);
      send_freed();
      send_poll();
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_POLL, 8'hFF);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'h02);
      send_word(KIND_DATA, 8'hFF);
      send_freed();
      send_word(KIND_DATA, 8'h00);
      budget_left--;
      frames_owed++;

      // budget used up, then a queue fuller than its slots
      configure(32'd1, 16'd2, 16'd2);
      send_poll();
      send_frame(32'd1);
      send_word(KIND_DATA, 8'h80);
      configure(32'd1, 16'd2, 16'd1);
      send_poll();
      send_word(KIND_DATA, 8'h7F);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               fm = 32'd1; fpp = 16'd1; slots = 16'd1;
            end
            1: begin
               fm = 32'hFFFF_FFFF; fpp = 16'hFFFF; slots = 16'hFFFF;
            end
            2: begin
               fm = 32'd5; fpp = 16'd0; slots = 16'd3;
            end
            5: begin
               fm = 32'd2; fpp = 16'hFFFF; slots = 16'd1;
            end
            3, 6: begin
               fm    = $urandom_range(1, 40);
               fpp   = $urandom_range(1, 4);
               slots = $urandom_range(1, 6);
            end
            default: begin
               fm = $urandom;
               if (fm == '0)
                  fm = 32'd1;
               fpp   = $urandom_range(0, 65535);
               slots = $urandom_range(1, 65535);
            end
         endcase
         configure(fm, fpp, slots);
         if (p == 1)
            hold_off_armed = 1'b1;
         random_phase((p == 2) ? 40 : 130);
      end

      // close the receiver: peer close mid-frame or idle, or a bad length
      close_mode = $urandom_range(0, 3);
      fm = 32'hFFFF_FFFF;
      if (close_mode == 1) begin
         fm = $urandom;
         if (fm == 32'hFFFF_FFFF)
            fm = 32'hFFFF_FFFE;
         if (fm == '0)
            fm = 32'd1;
      end
      configure(fm, 16'hFFFF, 16'hFFFF);
      if (close_mode != 3) begin
         send_poll();
         case (close_mode)
            0:       len = $urandom | 32'h8000_0000;
            1:       len = fm + 32'd1 + ($urandom % (32'hFFFF_FFFF - fm));
            default: len = '0;
         endcase
         for (int i = 3; i >= 0; i--)
            send_word(KIND_DATA, len[8*i +: 8]);
         if (close_mode == 0)
            repeat (3) send_word(KIND_DATA, $urandom);
      end
      if (close_mode == 0 || close_mode == 3)
         send_word(KIND_CLOSED, $urandom);
      for (int k = 0; k < 8; k++)
         send_word(k[1:0], $urandom);

      settle();
      repeat (5) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
